/* rtl/core/csvtok_pkg.sv */
package csvtok_pkg;

    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] SEP_RESET  = 8'd44;

    localparam int         PADDR_W    = 3;
    localparam logic [0:0] REG_SEP    = 1'b0;

    localparam int         MAX_TOK    = 3;

    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_DISCARD    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        Q_OUT  = 3'b001,
        Q_IN   = 3'b010,
        Q_PEND = 3'b100
    } qmode_t;

endpackage

/* rtl/core/csv_record_tokenizer_top.sv */
// CSV tokenizer with RFC 4180 style quoting. One text byte enters per request on the s_ side
// (s_tlast marks the final byte of the file); each byte gives zero to three tokens on the m_
// side: field characters, field ends, record ends and discard-field marks, m_tlast flagging
// the last token of a byte. A byte is registered on entry, decoded combinationally and its
// tokens fill a three-entry output buffer that drains one token per cycle while m_tready is
// high. Bytes yielding at most one token stream at one per clock while m_tready is high; a
// later byte waits until the last buffered token is taken. The field separator (reset ',') is
// written at APB address 0 by the user only while the stream is idle, unenforced by the block.
module csv_record_tokenizer_top
    import csvtok_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] in_byte
    input  logic               s_tlast,    // end_of_text

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,    // [7:0] out_byte
    output logic [1:0]         m_tuser,    // [1:0] kind
    output logic               m_tlast,    // last_of_run

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] sep_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;

    qmode_t     qmode_reg, qmode_next;
    logic       swallow_reg, swallow_next;
    logic       fhc_reg, fhc_next;
    logic       rhf_reg, rhf_next;

    kind_t      buf_kind_reg [MAX_TOK];
    logic [7:0] buf_byte_reg [MAX_TOK];
    logic [1:0] rem_reg;

    kind_t      tk_kind [MAX_TOK];
    logic [7:0] tk_byte [MAX_TOK];
    logic [1:0] tk_cnt;
    logic       quoted;

    logic       out_free;
    logic       proc;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_SEP) ? {24'd0, sep_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= SEP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_SEP) begin
            sep_reg <= pwdata[7:0];
        end
    end

    // handshake
    assign out_free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    // per-byte decode
    always_comb begin
        tk_kind      = '{default: KIND_CHAR};
        tk_byte      = '{default: 8'd0};
        tk_cnt       = 2'd0;
        qmode_next   = qmode_reg;
        swallow_next = 1'b0;
        fhc_next     = fhc_reg;
        rhf_next     = rhf_reg;
        quoted       = (qmode_reg == Q_IN);

        if (!(swallow_reg && in_byte_reg == CH_LF)) begin
            if (qmode_reg == Q_PEND && in_byte_reg == CH_QUOTE) begin
                // doubled quote inside quotes
                tk_kind[tk_cnt] = KIND_CHAR;
                tk_byte[tk_cnt] = CH_QUOTE;
                tk_cnt          = tk_cnt + 2'd1;
                fhc_next        = 1'b1;
                qmode_next      = Q_IN;
            end else if (!quoted && (in_byte_reg == CH_CR || in_byte_reg == CH_LF)) begin
                if (fhc_reg) begin
                    tk_kind[tk_cnt] = KIND_FIELD_END;
                    tk_cnt          = tk_cnt + 2'd1;
                end
                tk_kind[tk_cnt] = KIND_RECORD_END;
                tk_cnt          = tk_cnt + 2'd1;
                fhc_next        = 1'b0;
                rhf_next        = 1'b0;
                qmode_next      = Q_OUT;
                swallow_next    = 1'b1;
            end else if (in_byte_reg == CH_QUOTE) begin
                if (quoted) begin
                    qmode_next = Q_PEND;
                end else begin
                    qmode_next      = Q_IN;
                    tk_kind[tk_cnt] = KIND_DISCARD;
                    tk_cnt          = tk_cnt + 2'd1;
                    fhc_next        = 1'b0;
                end
            end else if (!quoted && in_byte_reg == sep_reg) begin
                tk_kind[tk_cnt] = KIND_FIELD_END;
                tk_cnt          = tk_cnt + 2'd1;
                rhf_next        = 1'b1;
                fhc_next        = 1'b0;
                qmode_next      = Q_OUT;
            end else begin
                tk_kind[tk_cnt] = KIND_CHAR;
                tk_byte[tk_cnt] = in_byte_reg;
                tk_cnt          = tk_cnt + 2'd1;
                fhc_next        = 1'b1;
                qmode_next      = quoted ? Q_IN : Q_OUT;
            end
        end

        // end of file: flush pending field and record, open quotes are dropped
        if (in_eot_reg) begin
            if (fhc_next) begin
                tk_kind[tk_cnt] = KIND_FIELD_END;
                tk_cnt          = tk_cnt + 2'd1;
                rhf_next        = 1'b1;
            end
            if (rhf_next) begin
                tk_kind[tk_cnt] = KIND_RECORD_END;
                tk_cnt          = tk_cnt + 2'd1;
            end
            qmode_next   = Q_OUT;
            swallow_next = 1'b0;
            fhc_next     = 1'b0;
            rhf_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qmode_reg   <= Q_OUT;
            swallow_reg <= 1'b0;
            fhc_reg     <= 1'b0;
            rhf_reg     <= 1'b0;
        end else if (proc) begin
            qmode_reg   <= qmode_next;
            swallow_reg <= swallow_next;
            fhc_reg     <= fhc_next;
            rhf_reg     <= rhf_next;
        end
    end

    // token buffer, head at entry 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else if (proc) begin
            rem_reg <= tk_cnt;
        end else if (m_tvalid && m_tready) begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            buf_kind_reg <= tk_kind;
            buf_byte_reg <= tk_byte;
        end else if (m_tvalid && m_tready) begin
            for (int i = 0; i < MAX_TOK - 1; i++) begin
                buf_kind_reg[i] <= buf_kind_reg[i+1];
                buf_byte_reg[i] <= buf_byte_reg[i+1];
            end
        end
    end

    assign m_tvalid = (rem_reg != 2'd0);
    assign m_tlast  = (rem_reg == 2'd1);
    assign m_tuser  = buf_kind_reg[0];
    assign m_tdata  = buf_byte_reg[0];

endmodule

/* rtl/core/csvtok_checker.sv */
module csvtok_checker
    import csvtok_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // stalled token holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output token changed while stalled");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_CHAR |-> m_tdata == 8'd0)
        else $error("non-character token carries a byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    // a field end that is not last in its run is always followed by a record end
    a_fe_then_re: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_FIELD_END && !m_tlast
        |=> m_tvalid && m_tuser == KIND_RECORD_END)
        else $error("field end not followed by record end");

endmodule

bind csv_record_tokenizer_top csvtok_checker u_csvtok_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
